[sv/arp_cache_resolver_macros.svh]
// Assertion macros for the ARP cache resolver.
`ifndef ARP_CACHE_RESOLVER_MACROS_SVH
`define ARP_CACHE_RESOLVER_MACROS_SVH
`ifndef SYNTHESIS
`define ARPC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ARPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ARPC_ASSERT_IMP(label, clk, rst, ante, cons)
`define ARPC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[sv/arpc_pkg.sv]
// Shared types and constants of the ARP cache resolver.
package arpc_pkg;
   localparam logic [3:0] CMD_RX = 4'd0;
   localparam logic [3:0] CMD_TICK = 4'd1;
   localparam logic [3:0] CMD_RESOLVE = 4'd2;
   localparam logic [3:0] CMD_ADD = 4'd3;
   localparam logic [3:0] CMD_DEL = 4'd4;
   localparam logic [3:0] CMD_CLEAR = 4'd5;
   localparam logic [3:0] CMD_PADD = 4'd6;
   localparam logic [3:0] CMD_PDEL = 4'd7;
   localparam logic [3:0] CMD_PCLEAR = 4'd8;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_IGNORED = 3'd1;
   localparam logic [2:0] ST_PENDING = 3'd2;
   localparam logic [2:0] ST_REQ_SENT = 3'd3;
   localparam logic [2:0] ST_FULL = 3'd4;
   localparam logic [2:0] ST_NOT_FOUND = 3'd5;

   localparam logic [15:0] OPC_REQUEST = 16'h0001;
   localparam logic [15:0] OPC_REPLY = 16'h0002;
   localparam logic [1:0] OP_REQUEST = 2'd1;
   localparam logic [1:0] OP_REPLY = 2'd2;

   localparam logic [1:0] KIND_PENDING = 2'd0;
   localparam logic [1:0] KIND_DYNAMIC = 2'd1;
   localparam logic [1:0] KIND_STATIC = 2'd2;

   localparam logic [10:0] TTL_LEARNED = 11'd1200;
   localparam logic [10:0] TTL_PENDING = 11'd180;
   localparam logic [31:0] IP_BCAST = 32'hFFFF_FFFF;
   localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_PSCAN,
      S_EXEC,
      S_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic scan_start;
      logic scan_step;
      logic pscan_start;
      logic pscan_step;
      logic exec;
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_last;
      logic pscan_last;
   } sts_type;
endpackage

[sv/arpc_ctrl.sv]
// Controller state machine of the ARP cache resolver.
`include "arp_cache_resolver_macros.svh"
module arpc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  arpc_pkg::sts_type sts,
   output arpc_pkg::ctl_type ctl,
   output logic              busy,
   output logic              done
);
   arpc_pkg::state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= arpc_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands. Every item scans the cache, then the proxy list.
   always_comb begin
      state_in = state_ff;
      ctl = '0;
      busy = 1'b1;
      done = 1'b0;
      case (state_ff)
         arpc_pkg::S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               ctl.load = 1'b1;
               ctl.scan_start = 1'b1;
               state_in = arpc_pkg::S_SCAN;
            end
         end
         arpc_pkg::S_SCAN: begin
            ctl.scan_step = 1'b1;
            if (sts.scan_last) begin
               ctl.pscan_start = 1'b1;
               state_in = arpc_pkg::S_PSCAN;
            end
         end
         arpc_pkg::S_PSCAN: begin
            ctl.pscan_step = 1'b1;
            if (sts.pscan_last) begin
               state_in = arpc_pkg::S_EXEC;
            end
         end
         arpc_pkg::S_EXEC: begin
            ctl.exec = 1'b1;
            state_in = arpc_pkg::S_DONE;
         end
         arpc_pkg::S_DONE: begin
            done = 1'b1;
            state_in = arpc_pkg::S_IDLE;
         end
         default: begin
            state_in = arpc_pkg::S_IDLE;
         end
      endcase
   end

   `ARPC_ASSERT_NEXT(a_start_leaves_idle, clock, reset, start && !busy, busy)
   `ARPC_ASSERT_NEXT(a_exec_then_done, clock, reset, ctl.exec, done)
   `ARPC_ASSERT_IMP(a_done_busy, clock, reset, done, busy)
endmodule

[sv/arpc_datapath.sv]
// Datapath of the ARP cache resolver: tables, scans and result registers.
`include "arp_cache_resolver_macros.svh"
module arpc_datapath #(
   parameter int CACHE_ENTRIES = 32,
   parameter int PROXY_ENTRIES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  arpc_pkg::ctl_type ctl,
   output arpc_pkg::sts_type sts,
   input  logic              done,
   input  logic [31:0]       own_ip,
   input  logic [47:0]       own_mac,
   input  logic [3:0]        req_cmd,
   input  logic [15:0]       req_arp_opcode,
   input  logic [47:0]       req_peer_mac,
   input  logic [31:0]       req_peer_ip,
   input  logic [31:0]       req_target_ip,
   input  logic              req_entry_static,
   output logic              rsp_valid,
   output logic [2:0]        rsp_status,
   output logic              rsp_send_frame,
   output logic [1:0]        rsp_frame_op,
   output logic [47:0]       rsp_frame_dst_mac,
   output logic [47:0]       rsp_frame_src_mac,
   output logic [31:0]       rsp_frame_src_ip,
   output logic [31:0]       rsp_frame_dst_ip,
   output logic [47:0]       rsp_lookup_mac,
   output logic              rsp_duplicate_ip,
   output logic              rsp_resolved
);
   localparam int CW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int PW = (PROXY_ENTRIES > 1) ? $clog2(PROXY_ENTRIES) : 1;

   // Stores. Valid bits in flip-flops, payload in plain arrays.
   logic [31:0] eip_ff [CACHE_ENTRIES];
   logic [47:0] emac_ff [CACHE_ENTRIES];
   logic [10:0] ettl_ff [CACHE_ENTRIES];
   logic [1:0]  ekind_ff [CACHE_ENTRIES];
   logic [CACHE_ENTRIES-1:0] eused_ff;
   logic [31:0] paddr_ff [PROXY_ENTRIES];
   logic [PROXY_ENTRIES-1:0] pused_ff;

   // Latched item.
   logic [3:0]  cmd_ff;
   logic [15:0] opc_ff;
   logic [47:0] pmac_ff;
   logic [31:0] pip_ff, tip_ff;
   logic        stat_ff;

   // Scan results.
   logic [CW-1:0] idx_ff;
   logic [PW-1:0] pidx_ff;
   logic          hit_ff, free_ok_ff, phit_ff, pfree_ok_ff, pthit_ff;
   logic [CW-1:0] hit_idx_ff, free_idx_ff;
   logic [PW-1:0] phit_idx_ff, pfree_idx_ff;

   logic [31:0] key_ip;
   assign key_ip = (cmd_ff == arpc_pkg::CMD_RESOLVE) ? tip_ff : pip_ff;

   assign sts.scan_last = (idx_ff == CW'(CACHE_ENTRIES - 1));
   assign sts.pscan_last = (pidx_ff == PW'(PROXY_ENTRIES - 1));

   // Item capture and the two scans; each keeps the lowest index.
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff <= req_cmd;
         opc_ff <= req_arp_opcode;
         pmac_ff <= req_peer_mac;
         pip_ff <= req_peer_ip;
         tip_ff <= req_target_ip;
         stat_ff <= req_entry_static;
      end
      if (ctl.scan_start) begin
         idx_ff <= '0;
         hit_ff <= 1'b0;
         free_ok_ff <= 1'b0;
         hit_idx_ff <= '0;
         free_idx_ff <= '0;
      end else if (ctl.scan_step) begin
         if (!sts.scan_last) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (eused_ff[idx_ff] && eip_ff[idx_ff] == key_ip && !hit_ff) begin
            hit_ff <= 1'b1;
            hit_idx_ff <= idx_ff;
         end
         if (!eused_ff[idx_ff] && !free_ok_ff) begin
            free_ok_ff <= 1'b1;
            free_idx_ff <= idx_ff;
         end
      end
      if (ctl.pscan_start) begin
         pidx_ff <= '0;
         phit_ff <= 1'b0;
         pthit_ff <= 1'b0;
         pfree_ok_ff <= 1'b0;
         phit_idx_ff <= '0;
         pfree_idx_ff <= '0;
      end else if (ctl.pscan_step) begin
         if (!sts.pscan_last) begin
            pidx_ff <= pidx_ff + 1'b1;
         end
         if (pused_ff[pidx_ff] && paddr_ff[pidx_ff] == pip_ff && !phit_ff) begin
            phit_ff <= 1'b1;
            phit_idx_ff <= pidx_ff;
         end
         if (pused_ff[pidx_ff] && paddr_ff[pidx_ff] == tip_ff) begin
            pthit_ff <= 1'b1;
         end
         if (!pused_ff[pidx_ff] && !pfree_ok_ff) begin
            pfree_ok_ff <= 1'b1;
            pfree_idx_ff <= pidx_ff;
         end
      end
   end

   // Tick ages one entry per scan step.
   logic tick_step;
   assign tick_step = ctl.scan_step && cmd_ff == arpc_pkg::CMD_TICK;

   // Execute decision.
   logic          w_en, w_new, w_proxy_add, del_e, del_p, clr_e, clr_p;
   logic [CW-1:0] w_idx;
   logic [31:0]   w_ip;
   logic [47:0]   w_mac;
   logic [1:0]    w_kind;
   logic [10:0]   w_ttl;
   logic [2:0]    status_in;
   logic          send_in, dup_in, resv_in;
   logic [1:0]    op_in;
   logic [47:0]   dmac_in, smac_in, lmac_in;
   logic [31:0]   sip_in, dip_in;
   logic          can_store;
   logic          was_pending;

   assign can_store = hit_ff || free_ok_ff;
   assign was_pending = hit_ff && ekind_ff[hit_idx_ff] == arpc_pkg::KIND_PENDING;

   always_comb begin
      w_en = 1'b0;
      w_new = !hit_ff;
      w_idx = hit_ff ? hit_idx_ff : free_idx_ff;
      w_ip = key_ip;
      w_mac = pmac_ff;
      w_kind = arpc_pkg::KIND_DYNAMIC;
      w_ttl = arpc_pkg::TTL_LEARNED;
      w_proxy_add = 1'b0;
      del_e = 1'b0;
      del_p = 1'b0;
      clr_e = 1'b0;
      clr_p = 1'b0;
      status_in = arpc_pkg::ST_OK;
      send_in = 1'b0;
      op_in = '0;
      dmac_in = '0;
      smac_in = '0;
      sip_in = '0;
      dip_in = '0;
      lmac_in = '0;
      dup_in = 1'b0;
      resv_in = 1'b0;
      case (cmd_ff)
         arpc_pkg::CMD_RX: begin
            if (opc_ff == arpc_pkg::OPC_REQUEST) begin
               if (pip_ff != own_ip) begin
                  w_en = can_store;
                  if (!can_store) status_in = arpc_pkg::ST_FULL;
               end
               if (tip_ff == own_ip || pthit_ff) begin
                  send_in = 1'b1;
                  op_in = arpc_pkg::OP_REPLY;
                  dmac_in = pmac_ff;
                  smac_in = own_mac;
                  sip_in = tip_ff;
                  dip_in = pip_ff;
               end
            end else if (opc_ff == arpc_pkg::OPC_REPLY) begin
               w_en = can_store;
               if (!can_store) status_in = arpc_pkg::ST_FULL;
               if (pip_ff == own_ip) begin
                  dup_in = 1'b1;
                  send_in = 1'b1;
                  op_in = arpc_pkg::OP_REQUEST;
                  dmac_in = arpc_pkg::MAC_BCAST;
                  smac_in = pmac_ff;
                  sip_in = own_ip;
               end else begin
                  resv_in = was_pending;
               end
            end else begin
               status_in = arpc_pkg::ST_IGNORED;
            end
         end
         arpc_pkg::CMD_TICK: begin
         end
         arpc_pkg::CMD_RESOLVE: begin
            if (tip_ff == arpc_pkg::IP_BCAST) begin
               lmac_in = arpc_pkg::MAC_BCAST;
            end else if (hit_ff) begin
               if (ekind_ff[hit_idx_ff] == arpc_pkg::KIND_PENDING) begin
                  status_in = arpc_pkg::ST_PENDING;
               end else begin
                  lmac_in = emac_ff[hit_idx_ff];
               end
            end else if (tip_ff == own_ip || free_ok_ff) begin
               w_en = tip_ff != own_ip;
               w_mac = '0;
               w_kind = arpc_pkg::KIND_PENDING;
               w_ttl = arpc_pkg::TTL_PENDING;
               send_in = 1'b1;
               op_in = arpc_pkg::OP_REQUEST;
               dmac_in = arpc_pkg::MAC_BCAST;
               smac_in = own_mac;
               sip_in = own_ip;
               dip_in = tip_ff;
               status_in = arpc_pkg::ST_REQ_SENT;
            end else begin
               status_in = arpc_pkg::ST_FULL;
            end
         end
         arpc_pkg::CMD_ADD: begin
            w_en = can_store;
            w_kind = stat_ff ? arpc_pkg::KIND_STATIC : arpc_pkg::KIND_DYNAMIC;
            if (!can_store) status_in = arpc_pkg::ST_FULL;
         end
         arpc_pkg::CMD_DEL: begin
            del_e = hit_ff;
            if (!hit_ff) status_in = arpc_pkg::ST_NOT_FOUND;
         end
         arpc_pkg::CMD_CLEAR: begin
            clr_e = 1'b1;
         end
         arpc_pkg::CMD_PADD: begin
            if (!phit_ff) begin
               w_proxy_add = pfree_ok_ff;
               if (!pfree_ok_ff) status_in = arpc_pkg::ST_FULL;
            end
         end
         arpc_pkg::CMD_PDEL: begin
            del_p = phit_ff;
            if (!phit_ff) status_in = arpc_pkg::ST_NOT_FOUND;
         end
         arpc_pkg::CMD_PCLEAR: begin
            clr_p = 1'b1;
         end
         default: begin
            status_in = arpc_pkg::ST_IGNORED;
         end
      endcase
   end

   // Cache payload writes.
   always_ff @(posedge clock) begin
      if (ctl.exec && w_en) begin
         if (w_new) eip_ff[w_idx] <= w_ip;
         emac_ff[w_idx] <= w_mac;
         ekind_ff[w_idx] <= w_kind;
         ettl_ff[w_idx] <= w_ttl;
      end else if (tick_step) begin
         ettl_ff[idx_ff] <= ettl_ff[idx_ff] - 11'd1;
      end
      if (ctl.exec && w_proxy_add) begin
         paddr_ff[pfree_idx_ff] <= pip_ff;
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         eused_ff <= '0;
         pused_ff <= '0;
      end else begin
         if (tick_step && eused_ff[idx_ff] && ekind_ff[idx_ff] != arpc_pkg::KIND_STATIC
             && ettl_ff[idx_ff] <= 11'd1) begin
            eused_ff[idx_ff] <= 1'b0;
         end
         if (ctl.exec) begin
            if (clr_e) eused_ff <= '0;
            if (w_en) eused_ff[w_idx] <= 1'b1;
            if (del_e) eused_ff[hit_idx_ff] <= 1'b0;
            if (clr_p) pused_ff <= '0;
            if (w_proxy_add) pused_ff[pfree_idx_ff] <= 1'b1;
            if (del_p) pused_ff[phit_idx_ff] <= 1'b0;
         end
      end
   end

   // Result registers, loaded on execute, valid in the cycle after.
   always_ff @(posedge clock) begin
      if (ctl.exec) begin
         rsp_status <= status_in;
         rsp_send_frame <= send_in;
         rsp_frame_op <= op_in;
         rsp_frame_dst_mac <= dmac_in;
         rsp_frame_src_mac <= smac_in;
         rsp_frame_src_ip <= sip_in;
         rsp_frame_dst_ip <= dip_in;
         rsp_lookup_mac <= lmac_in;
         rsp_duplicate_ip <= dup_in;
         rsp_resolved <= resv_in;
      end
   end
   assign rsp_valid = done;

   `ARPC_ASSERT_IMP(a_full_no_write, clock, reset, ctl.exec && !can_store, !w_en)
   `ARPC_ASSERT_NEXT(a_del_clears, clock, reset, ctl.exec && del_e, !eused_ff[$past(hit_idx_ff)])
   `ARPC_ASSERT_NEXT(a_padd_sets, clock, reset, ctl.exec && w_proxy_add && !clr_p, pused_ff[$past(pfree_idx_ff)])
endmodule

[sv/arp_cache_resolver.sv]
// Top level of the ARP cache resolver: configuration registers and glue.
// One item runs through the controller in order: it walks the cache one entry per cycle,
// then the proxy list one entry per cycle, then executes and shows the result in the next
// cycle. busy is high from the accepting edge until the result has been taken, so a new item
// can be accepted only once the last one is through. rsp_valid is high for exactly one cycle
// and the result cannot be held off.
module arp_cache_resolver #(
   parameter int CACHE_ENTRIES = 32,
   parameter int PROXY_ENTRIES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_cmd,
   input  logic [15:0] req_arp_opcode,
   input  logic [47:0] req_peer_mac,
   input  logic [31:0] req_peer_ip,
   input  logic [31:0] req_target_ip,
   input  logic        req_entry_static,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic        rsp_send_frame,
   output logic [1:0]  rsp_frame_op,
   output logic [47:0] rsp_frame_dst_mac,
   output logic [47:0] rsp_frame_src_mac,
   output logic [31:0] rsp_frame_src_ip,
   output logic [31:0] rsp_frame_dst_ip,
   output logic [47:0] rsp_lookup_mac,
   output logic        rsp_duplicate_ip,
   output logic        rsp_resolved,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [47:0] csr_wdata
);
   logic [31:0] own_ip_ff;
   logic [47:0] own_mac_ff;
   arpc_pkg::ctl_type ctl;
   arpc_pkg::sts_type sts;
   logic done;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff <= '0;
         own_mac_ff <= '0;
      end else if (csr_we) begin
         if (csr_index == 1'b0) own_ip_ff <= csr_wdata[31:0];
         else own_mac_ff <= csr_wdata;
      end
   end

   arpc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .sts(sts),
      .ctl(ctl), .busy(busy), .done(done)
   );

   arpc_datapath #(.CACHE_ENTRIES(CACHE_ENTRIES), .PROXY_ENTRIES(PROXY_ENTRIES)) u_dp (
      .clock(clock), .reset(reset), .ctl(ctl), .sts(sts), .done(done),
      .own_ip(own_ip_ff), .own_mac(own_mac_ff),
      .req_cmd(req_cmd), .req_arp_opcode(req_arp_opcode), .req_peer_mac(req_peer_mac),
      .req_peer_ip(req_peer_ip), .req_target_ip(req_target_ip),
      .req_entry_static(req_entry_static),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_send_frame(rsp_send_frame),
      .rsp_frame_op(rsp_frame_op), .rsp_frame_dst_mac(rsp_frame_dst_mac),
      .rsp_frame_src_mac(rsp_frame_src_mac), .rsp_frame_src_ip(rsp_frame_src_ip),
      .rsp_frame_dst_ip(rsp_frame_dst_ip), .rsp_lookup_mac(rsp_lookup_mac),
      .rsp_duplicate_ip(rsp_duplicate_ip), .rsp_resolved(rsp_resolved)
   );
endmodule
